// File: hdl/wbs_pkg.sv
// Shared types, codes and field layout for the waypoint beacon sequencer.
`default_nettype none

package wbs_pkg;

    // Store depth default (handed to the top-level parameter)
    localparam int MAX_WAYPOINTS_DEF = 64;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int COORD_W   = 24;
    localparam int TIME_W    = 32;
    localparam int EV_W      = 3;
    localparam int TIDX_W    = 6;
    localparam int PLEN_W    = 7;
    localparam int CFG_W     = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int WP_W      = 3 * COORD_W;

    // Stream widths (padded to whole bytes)
    localparam int S_DATA_BITS = 3 * COORD_W + 1 + TIME_W;
    localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = 1 + TIDX_W + 3 * COORD_W + PLEN_W;
    localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

    // Register reset values
    localparam logic [CFG_W-1:0] REACH_RADIUS_RST = 16'd768;
    localparam logic [CFG_W-1:0] HB_PERIOD_RST    = 16'd1000;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_REACH_RADIUS = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HB_PERIOD    = 1'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_START  = 2'd1,
        CMD_CANCEL = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [EV_W-1:0] {
        EV_NONE        = 3'd0,
        EV_HEARTBEAT   = 3'd1,
        EV_WP_REACHED  = 3'd2,
        EV_DEST        = 3'd3,
        EV_PLAYER_LOST = 3'd4,
        EV_INDEX_FAULT = 3'd5,
        EV_REJECTED    = 3'd6,
        EV_ACCEPTED    = 3'd7
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_COMPARE,
        ST_FETCH,
        ST_PUSH
    } state_t;

endpackage

`default_nettype wire

// File: hdl/waypoint_beacon_sequencer_core.sv
// Waypoint beacon sequencer: waypoint store, command sequencer and result register.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+----------------------------------------------
//  s_*     | in  | s_tvalid/tready  | tuser: command; tdata: coords, valid, now_ms
//  m_*     | out | m_tvalid/tready  | tuser: event_res; tdata: beacon status
//  cfg_*   | in  | cfg_we           | cfg_addr selects reach_radius / period
//
// Sequence: one item at a time. Append, cancel, idle tick and player-lost go
// from accept to result load; start adds a store read; a tick that checks
// distance passes difference, square and compare, and when it advances the
// next waypoint is then read from the store before the result load. The
// square/compare pipeline and the registered store read set these steps.
// Reset: control state clears at once; the store has no clearing pass and its
// entries are undefined until appended.
// Stalls: a result waits in the output register while m_tready is low; the next
// item is taken only once the result has been loaded.
`default_nettype none

module waypoint_beacon_sequencer_core
#(
    parameter int MAX_WAYPOINTS = wbs_pkg::MAX_WAYPOINTS_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [wbs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [wbs_pkg::CFG_W-1:0]         cfg_wdata,
    // input items
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // coord_x[23:0], coord_y[47:24], coord_z[71:48], player_valid[72],
    // now_ms[104:73], zero pad
    input  wire logic [wbs_pkg::S_DATA_W-1:0]      s_tdata,
    // command[1:0]
    input  wire logic [wbs_pkg::CMD_W-1:0]         s_tuser,
    // results
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // is_active[0], target_index[6:1], target_x[30:7], target_y[54:31],
    // target_z[78:55], path_length[85:79], zero pad
    output logic [wbs_pkg::M_DATA_W-1:0]           m_tdata,
    // event_res[2:0]
    output logic [wbs_pkg::EV_W-1:0]               m_tuser
);

    localparam int IDX_W = $clog2(MAX_WAYPOINTS);
    localparam int CNT_W = $clog2(MAX_WAYPOINTS + 1);
    localparam int CW    = wbs_pkg::COORD_W;
    localparam int TW    = wbs_pkg::TIME_W;

    // ---------------- input field split ----------------
    wbs_pkg::cmd_t            in_cmd;
    logic signed [CW-1:0]     in_x;
    logic signed [CW-1:0]     in_y;
    logic signed [CW-1:0]     in_z;
    logic                     in_pvalid;
    logic [TW-1:0]            in_now;
    logic                     in_accept;

    assign in_cmd    = wbs_pkg::cmd_t'(s_tuser);
    assign in_x      = s_tdata[CW-1:0];
    assign in_y      = s_tdata[2*CW-1:CW];
    assign in_z      = s_tdata[3*CW-1:2*CW];
    assign in_pvalid = s_tdata[3*CW];
    assign in_now    = s_tdata[3*CW+TW:3*CW+1];
    assign in_accept = s_tvalid && s_tready;

    // ---------------- configuration ----------------
    logic [wbs_pkg::CFG_W-1:0] reach_radius_reg;
    logic [wbs_pkg::CFG_W-1:0] hb_period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reach_radius_reg <= wbs_pkg::REACH_RADIUS_RST;
            hb_period_reg    <= wbs_pkg::HB_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                wbs_pkg::CFG_REACH_RADIUS: reach_radius_reg <= cfg_wdata;
                wbs_pkg::CFG_HB_PERIOD:    hb_period_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- state ----------------
    wbs_pkg::state_t          state_reg, state_next;
    logic                     armed_reg, armed_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [TW-1:0]            last_beat_reg, last_beat_next;
    logic                     m_tvalid_reg, m_tvalid_next;

    // payload
    wbs_pkg::event_t          ev_reg, ev_next;
    logic signed [CW-1:0]     tgt_x_reg, tgt_y_reg, tgt_z_reg;
    logic [TW-1:0]            now_reg;
    wbs_pkg::event_t          out_ev_reg;
    logic                     out_active_reg;
    logic [wbs_pkg::TIDX_W-1:0] out_idx_reg;
    logic signed [CW-1:0]     out_x_reg, out_y_reg, out_z_reg;
    logic [wbs_pkg::PLEN_W-1:0] out_len_reg;
    logic                     load_tgt;
    logic                     load_out;

    // ---------------- waypoint store ----------------
    logic [wbs_pkg::WP_W-1:0] wp_mem [MAX_WAYPOINTS];
    logic [wbs_pkg::WP_W-1:0] rd_data_reg;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_wr_addr;
    logic                     mem_re;
    logic [IDX_W-1:0]         mem_rd_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            wp_mem[mem_wr_addr] <= {in_z, in_y, in_x};
        if (mem_re)
            rd_data_reg <= wp_mem[mem_rd_addr];
    end

    // ---------------- distance check ----------------
    logic reached;

    wbs_reach_unit u_reach
    (
        .clk     (clk),
        .px      (in_x),
        .py      (in_y),
        .tx      (tgt_x_reg),
        .ty      (tgt_y_reg),
        .radius  (reach_radius_reg),
        .reached (reached)
    );

    // ---------------- derived terms ----------------
    logic [CNT_W-1:0]  idx_ext;
    logic              idx_ok;
    logic              out_free;
    logic [TW-1:0]     period_ext;
    logic [TW-1:0]     since_beat;
    logic [IDX_W+wbs_pkg::TIDX_W-1:0] idx_wide;
    logic [CNT_W+wbs_pkg::PLEN_W-1:0] cnt_wide;

    assign idx_ext    = CNT_W'(idx_reg);
    assign idx_ok     = armed_reg && (idx_ext < count_reg);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign period_ext = TW'(hb_period_reg);
    assign since_beat = now_reg - last_beat_reg;
    assign idx_wide   = {{wbs_pkg::TIDX_W{1'b0}}, idx_reg};
    assign cnt_wide   = {{wbs_pkg::PLEN_W{1'b0}}, count_reg};

    assign s_tready = (state_reg == wbs_pkg::ST_IDLE);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        armed_next     = armed_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        last_beat_next = last_beat_reg;
        ev_next        = ev_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        mem_we         = 1'b0;
        mem_wr_addr    = count_reg[IDX_W-1:0];
        mem_re         = 1'b0;
        mem_rd_addr    = '0;
        load_tgt       = 1'b0;
        load_out       = 1'b0;

        case (state_reg)
            wbs_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = wbs_pkg::ST_PUSH;
                    case (in_cmd)
                        wbs_pkg::CMD_APPEND:
                        begin
                            if (armed_reg || (count_reg >= CNT_W'(MAX_WAYPOINTS)))
                                ev_next = wbs_pkg::EV_REJECTED;
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                ev_next    = wbs_pkg::EV_ACCEPTED;
                            end
                        end
                        wbs_pkg::CMD_START:
                        begin
                            if (count_reg == '0)
                            begin
                                armed_next     = 1'b0;
                                idx_next       = '0;
                                last_beat_next = '0;
                                ev_next        = wbs_pkg::EV_REJECTED;
                            end
                            else
                            begin
                                armed_next     = 1'b1;
                                idx_next       = '0;
                                last_beat_next = in_now - period_ext;
                                ev_next        = wbs_pkg::EV_ACCEPTED;
                                mem_re         = 1'b1;
                                state_next     = wbs_pkg::ST_FETCH;
                            end
                        end
                        wbs_pkg::CMD_CANCEL:
                        begin
                            armed_next     = 1'b0;
                            count_next     = '0;
                            idx_next       = '0;
                            last_beat_next = '0;
                            ev_next        = wbs_pkg::EV_ACCEPTED;
                        end
                        default: // tick
                        begin
                            if (!armed_reg)
                                ev_next = wbs_pkg::EV_NONE;
                            else if (!in_pvalid || !idx_ok)
                            begin
                                armed_next     = 1'b0;
                                count_next     = '0;
                                idx_next       = '0;
                                last_beat_next = '0;
                                ev_next        = in_pvalid ? wbs_pkg::EV_INDEX_FAULT
                                                           : wbs_pkg::EV_PLAYER_LOST;
                            end
                            else
                                state_next = wbs_pkg::ST_SQUARE;
                        end
                    endcase
                end
            end

            wbs_pkg::ST_SQUARE:
                state_next = wbs_pkg::ST_COMPARE;

            wbs_pkg::ST_COMPARE:
            begin
                state_next = wbs_pkg::ST_PUSH;
                if (reached)
                begin
                    if (idx_ext + 1'b1 == count_reg)
                    begin
                        armed_next     = 1'b0;
                        count_next     = '0;
                        idx_next       = '0;
                        last_beat_next = '0;
                        ev_next        = wbs_pkg::EV_DEST;
                    end
                    else
                    begin
                        idx_next       = idx_reg + 1'b1;
                        last_beat_next = now_reg - period_ext;
                        ev_next        = wbs_pkg::EV_WP_REACHED;
                        mem_re         = 1'b1;
                        mem_rd_addr    = idx_reg + 1'b1;
                        state_next     = wbs_pkg::ST_FETCH;
                    end
                end
                else if (since_beat >= period_ext)
                begin
                    last_beat_next = now_reg;
                    ev_next        = wbs_pkg::EV_HEARTBEAT;
                end
                else
                    ev_next = wbs_pkg::EV_NONE;
            end

            wbs_pkg::ST_FETCH:
            begin
                load_tgt   = 1'b1;
                state_next = wbs_pkg::ST_PUSH;
            end

            wbs_pkg::ST_PUSH:
            begin
                if (out_free)
                begin
                    load_out      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = wbs_pkg::ST_IDLE;
                end
            end

            default:
                state_next = wbs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wbs_pkg::ST_IDLE;
            armed_reg     <= 1'b0;
            idx_reg       <= '0;
            count_reg     <= '0;
            last_beat_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            armed_reg     <= armed_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            last_beat_reg <= last_beat_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload: cached target, latched time, result register
    always_ff @(posedge clk)
    begin
        ev_reg <= ev_next;
        if (in_accept)
            now_reg <= in_now;
        if (load_tgt)
        begin
            tgt_x_reg <= rd_data_reg[CW-1:0];
            tgt_y_reg <= rd_data_reg[2*CW-1:CW];
            tgt_z_reg <= rd_data_reg[3*CW-1:2*CW];
        end
        if (load_out)
        begin
            out_ev_reg     <= ev_reg;
            out_active_reg <= armed_reg;
            out_idx_reg    <= idx_wide[wbs_pkg::TIDX_W-1:0];
            out_len_reg    <= cnt_wide[wbs_pkg::PLEN_W-1:0];
            out_x_reg      <= idx_ok ? tgt_x_reg : '0;
            out_y_reg      <= idx_ok ? tgt_y_reg : '0;
            out_z_reg      <= idx_ok ? tgt_z_reg : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_ev_reg;
    assign m_tdata  = {{(wbs_pkg::M_DATA_W - wbs_pkg::M_DATA_BITS){1'b0}},
                       out_len_reg, out_z_reg, out_y_reg, out_x_reg,
                       out_idx_reg, out_active_reg};

    // ---------------- checks ----------------
    a_armed_has_path: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg |-> (count_reg != '0))
        else $error("armed with an empty path");

    a_idx_in_path: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg |-> (idx_ext < count_reg))
        else $error("current index beyond loaded path");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |-> (idx_reg == '0 && last_beat_reg == '0))
        else $error("disarmed with stale index or timer");

    a_result_from_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == wbs_pkg::ST_PUSH))
        else $error("result raised outside the load step");

    a_fetch_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wbs_pkg::ST_FETCH) |-> $past(mem_re))
        else $error("target load without a store read");

endmodule

`default_nettype wire

// File: hdl/wbs_reach_unit.sv
// Squared planar distance against squared reach radius, two register stages.
`default_nettype none

module wbs_reach_unit
(
    input  wire logic                                clk,
    input  wire logic signed [wbs_pkg::COORD_W-1:0]  px,
    input  wire logic signed [wbs_pkg::COORD_W-1:0]  py,
    input  wire logic signed [wbs_pkg::COORD_W-1:0]  tx,
    input  wire logic signed [wbs_pkg::COORD_W-1:0]  ty,
    input  wire logic        [wbs_pkg::CFG_W-1:0]    radius,
    output logic                                     reached
);

    localparam int D_W  = wbs_pkg::COORD_W + 1;
    localparam int P_W  = 2 * D_W;
    localparam int SQ_W = P_W - 1;
    localparam int R2_W = 2 * wbs_pkg::CFG_W;

    logic signed [D_W-1:0]  dx_reg;
    logic signed [D_W-1:0]  dy_reg;
    logic signed [P_W-1:0]  prod_x;
    logic signed [P_W-1:0]  prod_y;
    logic        [SQ_W-1:0] sq_x_reg;
    logic        [SQ_W-1:0] sq_y_reg;
    logic        [R2_W-1:0] r2_reg;
    logic        [P_W-1:0]  dist2;

    // free-running: stage timing is tracked by the sequencer
    always_ff @(posedge clk)
    begin
        dx_reg   <= D_W'(px) - D_W'(tx);
        dy_reg   <= D_W'(py) - D_W'(ty);
        sq_x_reg <= prod_x[SQ_W-1:0];
        sq_y_reg <= prod_y[SQ_W-1:0];
        r2_reg   <= R2_W'(radius) * R2_W'(radius);
    end

    assign prod_x = dx_reg * dx_reg;
    assign prod_y = dy_reg * dy_reg;
    assign dist2  = P_W'(sq_x_reg) + P_W'(sq_y_reg);
    assign reached = dist2 < P_W'(r2_reg);

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the waypoint beacon sequencer: directed and random streams, predicted results.
module testbench;
    import wbs_pkg::*;

    localparam int MAXW = MAX_WAYPOINTS_DEF;
    // drain after the last result: covers the longest item (advancing tick) with margin
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT = 4000;
    localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] C_MIN = 24'sh800000;

    typedef struct packed {
        event_t              ev;
        logic                active;
        logic [TIDX_W-1:0]   leg;
        logic [COORD_W-1:0]  tx;
        logic [COORD_W-1:0]  ty;
        logic [COORD_W-1:0]  tz;
        logic [PLEN_W-1:0]   plen;
    } beacon_status_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [EV_W-1:0]       m_tuser;

    waypoint_beacon_sequencer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // predicted beacon state
    logic signed [COORD_W-1:0] route_x [MAXW];
    logic signed [COORD_W-1:0] route_y [MAXW];
    logic signed [COORD_W-1:0] route_z [MAXW];
    int unsigned     path_len;
    int unsigned     leg_idx;
    logic [31:0]     beat_ms;
    bit              beacon_armed;
    logic [CFG_W-1:0] radius_reg = REACH_RADIUS_RST;
    logic [CFG_W-1:0] period_reg = HB_PERIOD_RST;

    beacon_status_t expected_status [$];
    int unsigned    mismatches = 0;
    int unsigned    items_sent;
    int unsigned    quiet_cycles = 0;
    bit             src_gaps = 1'b1;
    bit             sink_gaps = 1'b1;
    logic [31:0]    now_ms;

    function automatic logic signed [COORD_W-1:0] clamp24(input longint v);
        if (v > 64'sd8388607)
            return C_MAX;
        if (v < -64'sd8388608)
            return C_MIN;
        return 24'(v);
    endfunction

    function automatic void drop_path();
        beacon_armed = 1'b0;
        path_len = 0;
        leg_idx = 0;
        beat_ms = '0;
    endfunction

    // Advance the predicted beacon by one item and return the status it reports.
    function automatic beacon_status_t step_beacon(input cmd_t cmd,
                                                   input logic signed [COORD_W-1:0] cx,
                                                   input logic signed [COORD_W-1:0] cy,
                                                   input logic signed [COORD_W-1:0] cz,
                                                   input logic pv,
                                                   input logic [31:0] now);
        beacon_status_t r;
        longint dx;
        longint dy;
        longint d2;
        longint r2;
        event_t ev;
        ev = EV_NONE;
        case (cmd)
            CMD_APPEND:
            begin
                if (beacon_armed || path_len >= MAXW)
                    ev = EV_REJECTED;
                else
                begin
                    route_x[path_len] = cx;
                    route_y[path_len] = cy;
                    route_z[path_len] = cz;
                    path_len++;
                    ev = EV_ACCEPTED;
                end
            end
            CMD_START:
            begin
                if (path_len == 0)
                begin
                    drop_path();
                    ev = EV_REJECTED;
                end
                else
                begin
                    beacon_armed = 1'b1;
                    leg_idx = 0;
                    beat_ms = now - {16'd0, period_reg};
                    ev = EV_ACCEPTED;
                end
            end
            CMD_CANCEL:
            begin
                drop_path();
                ev = EV_ACCEPTED;
            end
            default:
            begin
                if (!beacon_armed)
                    ev = EV_NONE;
                else if (!pv)
                begin
                    drop_path();
                    ev = EV_PLAYER_LOST;
                end
                else if (leg_idx >= path_len)
                begin
                    drop_path();
                    ev = EV_INDEX_FAULT;
                end
                else
                begin
                    dx = longint'(cx) - longint'(route_x[leg_idx]);
                    dy = longint'(cy) - longint'(route_y[leg_idx]);
                    d2 = dx * dx + dy * dy;
                    r2 = longint'(radius_reg) * longint'(radius_reg);
                    if (d2 < r2)
                    begin
                        if (leg_idx + 1 == path_len)
                        begin
                            drop_path();
                            ev = EV_DEST;
                        end
                        else
                        begin
                            leg_idx++;
                            beat_ms = now - {16'd0, period_reg};
                            ev = EV_WP_REACHED;
                        end
                    end
                    else if (32'(now - beat_ms) >= {16'd0, period_reg})
                    begin
                        beat_ms = now;
                        ev = EV_HEARTBEAT;
                    end
                end
            end
        endcase
        r.ev = ev;
        r.active = beacon_armed;
        r.leg = leg_idx[TIDX_W-1:0];
        if (beacon_armed && leg_idx < path_len)
        begin
            r.tx = route_x[leg_idx];
            r.ty = route_y[leg_idx];
            r.tz = route_z[leg_idx];
        end
        else
        begin
            r.tx = '0;
            r.ty = '0;
            r.tz = '0;
        end
        r.plen = path_len[PLEN_W-1:0];
        return r;
    endfunction

    // Present one item after a random gap (none while src_gaps is clear); returns at the accepting edge.
    task automatic send_item(input cmd_t cmd,
                             input logic signed [COORD_W-1:0] cx,
                             input logic signed [COORD_W-1:0] cy,
                             input logic signed [COORD_W-1:0] cz,
                             input logic pv,
                             input logic [31:0] now);
        int unsigned gap;
        gap = src_gaps ? $urandom_range(9) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {{(S_DATA_W - S_DATA_BITS){1'b0}}, now, pv, cz, cy, cx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_status.push_back(step_beacon(cmd, cx, cy, cz, pv, now));
        items_sent++;
    endtask

    // Hold the source off until every result is back and the block is idle.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_registers(input logic [CFG_W-1:0] radius,
                                     input logic [CFG_W-1:0] period);
        settle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_REACH_RADIUS;
        cfg_wdata <= radius;
        @(negedge clk);
        cfg_addr <= CFG_HB_PERIOD;
        cfg_wdata <= period;
        @(negedge clk);
        cfg_we <= 1'b0;
        radius_reg = radius;
        period_reg = period;
    endtask

    task automatic send_noise();
        send_item(cmd_t'($urandom_range(3)), 24'($urandom), 24'($urandom), 24'($urandom),
                  1'($urandom), $urandom);
    endtask

    // Tick aimed at the current target: inside the radius, on its edge, scattered around it, or player lost.
    task automatic send_aimed_tick();
        int unsigned pick;
        longint ox;
        longint oy;
        longint half;
        longint span;
        longint tx;
        longint ty;
        pick = $urandom_range(99);
        if ($urandom_range(49) == 0)
            now_ms = $urandom;
        else
            now_ms = now_ms + $urandom_range({16'd0, period_reg} + 32'd40);
        tx = beacon_armed ? longint'(route_x[leg_idx]) : 0;
        ty = beacon_armed ? longint'(route_y[leg_idx]) : 0;
        half = longint'(radius_reg) / 2;
        span = 4 * longint'(radius_reg) + 4096;
        if (pick < 40)
        begin
            ox = longint'($urandom_range(32'(2 * half))) - half;
            oy = longint'($urandom_range(32'(2 * half))) - half;
        end
        else if (pick < 46)
        begin
            // exactly on the radius: not reached
            ox = $urandom_range(1) ? longint'(radius_reg) : -longint'(radius_reg);
            oy = 0;
        end
        else
        begin
            ox = longint'($urandom_range(32'(2 * span))) - span;
            oy = longint'($urandom_range(32'(2 * span))) - span;
        end
        send_item(CMD_TICK, clamp24(tx + ox), clamp24(ty + oy), 24'($urandom),
                  pick < 97, now_ms);
    endtask

    // Clear, load a path, start and walk it until the beacon drops out or 40 ticks have been sent.
    task automatic run_journey();
        int unsigned n;
        int unsigned ticks;
        logic signed [COORD_W-1:0] wx;
        logic signed [COORD_W-1:0] wy;
        src_gaps = ($urandom_range(3) != 0);
        sink_gaps = ($urandom_range(3) != 0);
        if (beacon_armed || path_len != 0)
            send_item(CMD_CANCEL, 24'($urandom), 24'($urandom), 24'($urandom), 1'($urandom),
                      $urandom);
        n = ($urandom_range(15) == 0) ? $urandom_range(MAXW, 1) : $urandom_range(6, 1);
        wx = 24'($urandom);
        wy = 24'($urandom);
        repeat (n)
        begin
            if ($urandom_range(3) == 0)
            begin
                wx = 24'($urandom);
                wy = 24'($urandom);
            end
            else
            begin
                wx = clamp24(longint'(wx) + longint'($urandom_range(40000)) - 20000);
                wy = clamp24(longint'(wy) + longint'($urandom_range(40000)) - 20000);
            end
            send_item(CMD_APPEND, wx, wy, 24'($urandom), 1'($urandom), $urandom);
        end
        now_ms = now_ms + $urandom_range(5000);
        send_item(CMD_START, 24'($urandom), 24'($urandom), 24'($urandom), 1'($urandom), now_ms);
        ticks = 0;
        while (beacon_armed && ticks < 40)
        begin
            if ($urandom_range(29) == 0)
                send_noise();
            else
                send_aimed_tick();
            ticks++;
        end
    endtask

    task automatic random_traffic(input int unsigned budget);
        int unsigned stop_at;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(9) < 8)
                run_journey();
            else
                repeat ($urandom_range(5, 1)) send_noise();
        end
    endtask

    task automatic test_directed();
        logic [31:0] t;
        t = 32'hFFFF_FF00;
        send_item(CMD_TICK, 0, 0, 0, 1'b1, t);                  // idle tick does nothing
        send_item(CMD_START, 0, 0, 0, 1'b0, t);                 // start on an empty store
        send_item(CMD_CANCEL, C_MAX, C_MIN, C_MAX, 1'b1, 32'hFFFF_FFFF);
        send_item(CMD_APPEND, C_MAX, C_MIN, C_MAX, 1'b1, 32'hFFFF_FFFF);
        send_item(CMD_APPEND, C_MIN, C_MAX, C_MIN, 1'b0, 32'd0);
        send_item(CMD_APPEND, 0, 0, 0, 1'b1, 32'd0);
        send_item(CMD_START, 0, 0, 0, 1'b0, t);
        send_item(CMD_APPEND, 5, 5, 5, 1'b1, t);                // refused while armed
        send_item(CMD_TICK, 0, 0, C_MIN, 1'b1, t);              // primed heartbeat
        send_item(CMD_TICK, 0, 0, 0, 1'b1, t + 32'd999);        // one short of the period
        send_item(CMD_TICK, 0, 0, 0, 1'b1, t + 32'd1000);       // time wraps through zero
        send_item(CMD_TICK, C_MAX, C_MIN, 0, 1'b1, t + 32'd1001);
        send_item(CMD_TICK, C_MIN + 768, C_MAX, 0, 1'b1, t + 32'd1002);  // on the radius
        send_item(CMD_TICK, C_MIN, C_MAX - 767, 0, 1'b1, t + 32'd1003);
        send_item(CMD_START, 0, 0, 0, 1'b1, t + 32'd1004);      // restart while armed
        send_item(CMD_TICK, 1, 1, 1, 1'b0, t + 32'd1005);       // player lost
        send_item(CMD_TICK, 0, 0, 0, 1'b1, t + 32'd1006);
        send_item(CMD_APPEND, 100, -100, 7, 1'b0, 32'd0);
        send_item(CMD_APPEND, 2000, 2000, -7, 1'b0, 32'd0);
        send_item(CMD_START, 0, 0, 0, 1'b0, 32'd0);
        send_item(CMD_TICK, 600, -600, 0, 1'b1, 32'd1);
        send_item(CMD_TICK, 2000, 2000, 0, 1'b1, 32'd2);        // destination
        send_item(CMD_APPEND, -3, 3, 0, 1'b1, 32'd3);
        send_item(CMD_START, 0, 0, 0, 1'b1, 32'd4);
        send_item(CMD_CANCEL, 0, 0, 0, 1'b0, 32'd5);            // cancel while armed
    endtask

    task automatic test_full_store();
        send_item(CMD_CANCEL, 0, 0, 0, 1'b0, 32'd0);
        repeat (MAXW)
            send_item(CMD_APPEND, 24'($urandom), 24'($urandom), 24'($urandom), 1'($urandom),
                      $urandom);
        send_item(CMD_APPEND, 1, 2, 3, 1'b1, 32'd0);            // store full
        now_ms = $urandom;
        send_item(CMD_START, 0, 0, 0, 1'b1, now_ms);
        repeat (6)
        begin
            now_ms = now_ms + 32'd7;
            send_item(CMD_TICK, route_x[leg_idx], route_y[leg_idx], 0, 1'b1, now_ms);
        end
        send_item(CMD_CANCEL, 0, 0, 0, 1'b1, now_ms);
    endtask

    task automatic test_never_reached();
        program_registers(16'd0, 16'hFFFF);
        random_traffic(150);
    endtask

    task automatic test_wide_radius();
        program_registers(16'hFFFF, 16'd1);
        random_traffic(150);
    endtask

    task automatic test_zero_period();
        program_registers(16'd300, 16'd0);
        random_traffic(150);
    endtask

    task automatic test_random_settings();
        program_registers(16'($urandom_range(4000, 1)), 16'($urandom_range(5000, 1)));
        random_traffic(300);
    endtask

    task automatic test_default_settings();
        program_registers(REACH_RADIUS_RST, HB_PERIOD_RST);
        random_traffic(200);
    endtask

    function automatic void compare_field(input string field, input longint want,
                                          input longint got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Result checker: each accepted result against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        beacon_status_t want;
        beacon_status_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.ev = event_t'(m_tuser);
            got.active = m_tdata[0];
            got.leg = m_tdata[6:1];
            got.tx = m_tdata[30:7];
            got.ty = m_tdata[54:31];
            got.tz = m_tdata[78:55];
            got.plen = m_tdata[85:79];
            if (expected_status.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual event %0d",
                         $time, m_tuser);
                mismatches++;
            end
            else
            begin
                want = expected_status.pop_front();
                compare_field("event_res", want.ev, got.ev);
                compare_field("is_active", want.active, got.active);
                compare_field("target_index", want.leg, got.leg);
                compare_field("target_x", want.tx, got.tx);
                compare_field("target_y", want.ty, got.ty);
                compare_field("target_z", want.tz, got.tz);
                compare_field("path_length", want.plen, got.plen);
            end
        end
    end

    // Result sink: random hold-off before each result, none while sink_gaps is clear.
    initial
    begin : result_sink
        int unsigned stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = sink_gaps ? $urandom_range(9) : 0;
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready))
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Watchdog: too long with no item moving on either side ends the run.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin : run
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_REACH_RADIUS;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_APPEND;
        items_sent = 0;
        now_ms = $urandom;
        drop_path();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_full_store();
        test_never_reached();
        test_wide_radius();
        test_zero_period();
        test_random_settings();
        test_default_settings();

        settle();
        if (mismatches == 0 && expected_status.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule

// File: waypoint_beacon_sequencer_core.f
hdl/wbs_pkg.sv
hdl/wbs_reach_unit.sv
hdl/waypoint_beacon_sequencer_core.sv
test/testbench.sv
